// ----- rtl/nd_point_projection_assert.svh -----
// Assertion macros for the projection RTL.
// Needs nothing else; take it in with an include at the top of a file.
`ifndef ND_POINT_PROJECTION_ASSERT_SVH
`define ND_POINT_PROJECTION_ASSERT_SVH

// Check a condition on every clock edge outside reset.
`define NDP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ndp assertion failed");

// Check a consequence in the cycle after a trigger.
`define NDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ndp assertion failed");

`endif

// ----- rtl/ndp_pkg.sv -----
// Shared widths, register codes and transfer types for the point projection.
// No dependencies.
package ndp_pkg;

    localparam int MAX_DIM  = 5;
    localparam int DEF_DIM  = 5;
    localparam int LANE_W   = 12;
    localparam int REG_W    = 60;
    localparam int COORD_W  = 16;
    localparam int P_W      = 17;
    localparam int PRD_W    = 29;
    localparam int DOT_W    = 32;
    localparam int DVSR_W   = 32;
    localparam int NSQ_W    = 25;
    localparam int Q_W      = 42;
    localparam int INV_W    = 24;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_X       = 3'd0,
        CFG_AXIS_Y       = 3'd1,
        CFG_VIEW_NORMAL  = 3'd2,
        CFG_CAMERA_SHIFT = 3'd3,
        CFG_PERSPECTIVE  = 3'd4,
        CFG_INV_NORM_X   = 3'd5,
        CFG_INV_NORM_Y   = 3'd6,
        CFG_NORMAL_SQ    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_W-1:0] axis_x;
        logic [REG_W-1:0] axis_y;
        logic [REG_W-1:0] view_normal;
        logic [REG_W-1:0] camera_shift;
        logic             perspective_mode;
        logic [INV_W-1:0] inv_norm_x;
        logic [INV_W-1:0] inv_norm_y;
        logic [NSQ_W-1:0] normal_sq;
    } t_cfg;

    // front to back: shifted point, its normal dot and the signs of the axis dots
    typedef struct packed {
        logic [MAX_DIM-1:0][P_W-1:0] p;
        logic [DOT_W-1:0]            d;
        logic                        neg_x;
        logic                        neg_y;
    } t_mid;

    typedef struct packed {
        logic [OUT_W-1:0] screen_x;
        logic [OUT_W-1:0] screen_y;
        logic             visible;
    } t_out;

    function automatic logic signed [LANE_W-1:0] get_lane(input logic [REG_W-1:0] r,
                                                          input int unsigned i);
        return r[i*LANE_W +: LANE_W];
    endfunction

endpackage

// ----- rtl/ndp_fifo.sv -----
// Small register queue with a combinational head.
// No package dependency; uses the assertion macro header.
`include "nd_point_projection_assert.svh"

module ndp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (rd) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `NDP_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `NDP_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `NDP_ASSERT_NEXT(a_fill, i_clk, i_rst_n, i_push && !i_pop && !o_full, r_count == $past(r_count) + 1'b1)
    `NDP_ASSERT_NEXT(a_drain, i_clk, i_rst_n, i_pop && !i_push && !o_empty, r_count == $past(r_count) - 1'b1)

endmodule

// ----- rtl/ndp_front.sv -----
// Front end: camera shift, lane products and the three dot products.
// Depends on ndp_pkg.
module ndp_front #(
    parameter int DIMENSION = ndp_pkg::DEF_DIM
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_push,
    input  logic [ndp_pkg::MAX_DIM-1:0][ndp_pkg::COORD_W-1:0] i_coord,
    input  ndp_pkg::t_cfg                                  i_cfg,
    input  logic                                           i_mid_full,
    output logic                                           o_full,
    output logic                                           o_mid_push,
    output ndp_pkg::t_mid                                  o_mid_data
);
    import ndp_pkg::*;

    logic                    en;
    logic [2:0]              r_vld;
    logic signed [P_W-1:0]   n_p  [MAX_DIM];
    logic signed [P_W-1:0]   r_p1 [MAX_DIM];
    logic signed [P_W-1:0]   r_p2 [MAX_DIM];
    logic signed [P_W-1:0]   r_p3 [MAX_DIM];
    logic signed [PRD_W-1:0] n_pn [MAX_DIM];
    logic signed [PRD_W-1:0] n_px [MAX_DIM];
    logic signed [PRD_W-1:0] n_py [MAX_DIM];
    logic signed [PRD_W-1:0] r_pn [MAX_DIM];
    logic signed [PRD_W-1:0] r_px [MAX_DIM];
    logic signed [PRD_W-1:0] r_py [MAX_DIM];
    logic signed [DOT_W-1:0] n_d;
    logic signed [DOT_W-1:0] n_x;
    logic signed [DOT_W-1:0] n_y;
    logic signed [DOT_W-1:0] r_d;
    logic                    r_neg_x;
    logic                    r_neg_y;

    // hold the whole front while its last stage cannot hand over
    assign en         = !(r_vld[2] && i_mid_full);
    assign o_full     = !en;
    assign o_mid_push = en && r_vld[2];

    always_comb begin
        for (int i = 0; i < MAX_DIM; i++) begin
            if (i < DIMENSION) begin
                n_p[i] = $signed(i_coord[i]) - (get_lane(i_cfg.camera_shift, i) <<< 4);
            end else begin
                n_p[i] = '0;
            end
            n_pn[i] = get_lane(i_cfg.view_normal, i) * r_p1[i];
            n_px[i] = get_lane(i_cfg.axis_x, i) * r_p1[i];
            n_py[i] = get_lane(i_cfg.axis_y, i) * r_p1[i];
        end
    end

    always_comb begin
        n_d = '0;
        n_x = '0;
        n_y = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            n_d = n_d + r_pn[i];
            n_x = n_x + r_px[i];
            n_y = n_y + r_py[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[1:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_p1[i] <= n_p[i];
                r_p2[i] <= r_p1[i];
                r_p3[i] <= r_p2[i];
                r_pn[i] <= n_pn[i];
                r_px[i] <= n_px[i];
                r_py[i] <= n_py[i];
            end
            r_d     <= n_d;
            r_neg_x <= n_x[DOT_W-1];
            r_neg_y <= n_y[DOT_W-1];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DIM; i++) begin
            o_mid_data.p[i] = r_p3[i];
        end
        o_mid_data.d     = r_d;
        o_mid_data.neg_x = r_neg_x;
        o_mid_data.neg_y = r_neg_y;
    end

endmodule

// ----- rtl/ndp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on ndp_pkg.
module ndp_div #(
    parameter int PL_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [ndp_pkg::Q_W-1:0]     i_dvnd,
    input  logic [ndp_pkg::DVSR_W-1:0]  i_dvsr,
    input  logic [PL_W-1:0]             i_pl,
    output logic                        o_vld,
    output logic [ndp_pkg::Q_W-1:0]     o_quo,
    output logic [PL_W-1:0]             o_pl
);
    import ndp_pkg::*;

    logic              r_vld  [Q_W];
    logic [DVSR_W-1:0] r_rem  [Q_W];
    logic [DVSR_W-1:0] r_dvsr [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [PL_W-1:0]   r_pl   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stg
        logic              vld_in;
        logic [DVSR_W-1:0] rem_in;
        logic [DVSR_W-1:0] dvsr_in;
        logic [Q_W-1:0]    quo_in;
        logic [PL_W-1:0]   pl_in;
        logic [DVSR_W:0]   trial;
        logic [DVSR_W:0]   diff;
        logic              take;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign dvsr_in = i_dvsr;
            assign quo_in  = '0;
            assign pl_in   = i_pl;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign dvsr_in = r_dvsr[k-1];
            assign quo_in  = r_quo[k-1];
            assign pl_in   = r_pl[k-1];
        end

        // bring down the next dividend bit, subtract where it fits
        assign trial = {rem_in, i_dvnd[Q_W-1-k]};
        assign diff  = trial - {1'b0, dvsr_in};
        assign take  = (trial >= {1'b0, dvsr_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
                r_dvsr[k] <= dvsr_in;
                r_quo[k]  <= {quo_in[Q_W-2:0], take};
                r_pl[k]   <= pl_in;
            end
        end
    end

    assign o_vld = r_vld[Q_W-1];
    assign o_quo = r_quo[Q_W-1];
    assign o_pl  = r_pl[Q_W-1];

endmodule

// ----- rtl/ndp_back.sv -----
// Back end: perspective coefficient, point rescale, axis dots and output scaling.
// Depends on ndp_pkg and ndp_div.
module ndp_back #(
    parameter int DIMENSION = ndp_pkg::DEF_DIM
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ndp_pkg::t_cfg i_cfg,
    input  logic          i_mid_empty,
    input  ndp_pkg::t_mid i_mid_data,
    input  logic          i_out_full,
    output logic          o_mid_pop,
    output logic          o_out_push,
    output ndp_pkg::t_out o_out_data
);
    import ndp_pkg::*;

    localparam int CP_W  = 59;
    localparam int QV_W  = 44;
    localparam int AP_W  = 56;
    localparam int DQ_W  = 59;
    localparam int MAG_W = 58;
    localparam int LO_W  = 32 + INV_W;
    localparam int HI_W  = MAG_W - 32 + INV_W;
    localparam int R_W   = HI_W + 6;
    localparam int PAD_W = Q_W - NSQ_W;
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic zero;
        logic neg_d;
        logic neg_x;
        logic neg_y;
    } t_flg;

    typedef struct packed {
        logic [MAX_DIM-1:0][P_W-1:0] p;
        t_flg                        f;
    } t_dpl;

    function automatic logic [OUT_W-1:0] scale_sat(input logic [LO_W-1:0] lo,
                                                   input logic [HI_W-1:0] hi,
                                                   input logic neg);
        logic [LO_W:0]    lr;
        logic [R_W-1:0]   r;
        logic [R_W-1:0]   nr;
        logic [OUT_W-1:0] res;
        lr = {1'b0, lo} + (LO_W+1)'(1 << 26);
        r  = R_W'({hi, 5'b0}) + R_W'(lr[LO_W:27]);
        nr = -r;
        if (neg) begin
            res = (r > R_W'(OUT_MIN)) ? OUT_MIN : nr[OUT_W-1:0];
        end else begin
            res = (r > R_W'(OUT_MAX)) ? OUT_MAX : r[OUT_W-1:0];
        end
        return res;
    endfunction

    logic                    en;
    logic [6:0]              r_v;
    logic                    r0_vld;
    t_dpl                    r0_pl;
    logic [DVSR_W-1:0]       r0_mag;
    logic [DOT_W-1:0]        neg_d_val;
    logic                    dv_vld;
    logic [Q_W-1:0]          dv_quo;
    t_dpl                    dv_pl;

    logic signed [CP_W-1:0]  n1_cp [MAX_DIM];
    logic signed [CP_W-1:0]  r1_cp [MAX_DIM];
    logic [MAX_DIM-1:0][P_W-1:0] r1_p;
    t_flg                    r1_f;
    logic signed [QV_W-1:0]  n2_q  [MAX_DIM];
    logic signed [QV_W-1:0]  r2_q  [MAX_DIM];
    t_flg                    r2_f;
    logic signed [AP_W-1:0]  n3_ax [MAX_DIM];
    logic signed [AP_W-1:0]  n3_ay [MAX_DIM];
    logic signed [AP_W-1:0]  r3_ax [MAX_DIM];
    logic signed [AP_W-1:0]  r3_ay [MAX_DIM];
    t_flg                    r3_f;
    logic signed [DQ_W-1:0]  n4_dx;
    logic signed [DQ_W-1:0]  n4_dy;
    logic signed [DQ_W-1:0]  r4_dx;
    logic signed [DQ_W-1:0]  r4_dy;
    t_flg                    r4_f;
    logic [DQ_W-1:0]         ng_dx;
    logic [DQ_W-1:0]         ng_dy;
    logic [MAG_W-1:0]        r5_mx;
    logic [MAG_W-1:0]        r5_my;
    logic                    r5_sx;
    logic                    r5_sy;
    t_flg                    r5_f;
    logic [LO_W-1:0]         n6_lox;
    logic [LO_W-1:0]         n6_loy;
    logic [HI_W-1:0]         n6_hix;
    logic [HI_W-1:0]         n6_hiy;
    logic [LO_W-1:0]         r6_lox;
    logic [LO_W-1:0]         r6_loy;
    logic [HI_W-1:0]         r6_hix;
    logic [HI_W-1:0]         r6_hiy;
    logic                    r6_sx;
    logic                    r6_sy;
    t_flg                    r6_f;
    t_out                    n7_out;
    t_out                    r7_out;

    // stall everything at once when the result queue cannot take the last stage
    assign en         = !(r_v[6] && i_out_full);
    assign o_mid_pop  = en && !i_mid_empty;
    assign o_out_push = en && r_v[6];
    assign o_out_data = r7_out;
    assign neg_d_val  = -i_mid_data.d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r_v    <= '0;
        end else if (en) begin
            r0_vld <= o_mid_pop;
            r_v    <= {r_v[5:0], dv_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_pl.p       <= i_mid_data.p;
            r0_pl.f.zero  <= (i_mid_data.d == '0);
            r0_pl.f.neg_d <= i_mid_data.d[DOT_W-1];
            r0_pl.f.neg_x <= i_mid_data.neg_x;
            r0_pl.f.neg_y <= i_mid_data.neg_y;
            r0_mag        <= i_mid_data.d[DOT_W-1] ? neg_d_val : i_mid_data.d;
        end
    end

    ndp_div #(
        .PL_W ($bits(t_dpl))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r0_vld),
        .i_dvnd  ({i_cfg.normal_sq, {PAD_W{1'b0}}}),
        .i_dvsr  (r0_mag),
        .i_pl    (r0_pl),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_pl    (dv_pl)
    );

    always_comb begin
        for (int i = 0; i < MAX_DIM; i++) begin
            n1_cp[i] = $signed({1'b0, dv_quo}) * $signed(dv_pl.p[i]);
        end
    end

    // rescale in perspective mode, rounding ties away from zero
    always_comb begin
        logic signed [CP_W-1:0] rnd;
        logic signed [CP_W-1:0] sh;
        logic signed [QV_W-1:0] shq;
        for (int i = 0; i < MAX_DIM; i++) begin
            rnd = r1_cp[i][CP_W-1] ? CP_W'(32767) : CP_W'(32768);
            sh  = (r1_cp[i] + rnd) >>> 16;
            shq = sh[QV_W-1:0];
            if (i >= DIMENSION) begin
                n2_q[i] = '0;
            end else if (i_cfg.perspective_mode) begin
                n2_q[i] = shq - (get_lane(i_cfg.view_normal, i) <<< 1);
            end else begin
                n2_q[i] = $signed(r1_p[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DIM; i++) begin
            n3_ax[i] = get_lane(i_cfg.axis_x, i) * r2_q[i];
            n3_ay[i] = get_lane(i_cfg.axis_y, i) * r2_q[i];
        end
        n4_dx = '0;
        n4_dy = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            n4_dx = n4_dx + r3_ax[i];
            n4_dy = n4_dy + r3_ay[i];
        end
    end

    assign ng_dx  = -r4_dx;
    assign ng_dy  = -r4_dy;
    assign n6_lox = r5_mx[31:0] * i_cfg.inv_norm_x;
    assign n6_loy = r5_my[31:0] * i_cfg.inv_norm_y;
    assign n6_hix = r5_mx[MAG_W-1:32] * i_cfg.inv_norm_x;
    assign n6_hiy = r5_my[MAG_W-1:32] * i_cfg.inv_norm_y;

    always_comb begin
        if (i_cfg.perspective_mode && r6_f.zero) begin
            n7_out.screen_x = r6_f.neg_x ? OUT_MIN : OUT_MAX;
            n7_out.screen_y = r6_f.neg_y ? OUT_MIN : OUT_MAX;
        end else begin
            n7_out.screen_x = scale_sat(r6_lox, r6_hix, r6_sx);
            n7_out.screen_y = scale_sat(r6_loy, r6_hiy, r6_sy);
        end
        n7_out.visible = !(i_cfg.perspective_mode && r6_f.neg_d);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r1_cp[i] <= n1_cp[i];
                r2_q[i]  <= n2_q[i];
                r3_ax[i] <= n3_ax[i];
                r3_ay[i] <= n3_ay[i];
            end
            r1_p   <= dv_pl.p;
            r1_f   <= dv_pl.f;
            r2_f   <= r1_f;
            r3_f   <= r2_f;
            r4_dx  <= n4_dx;
            r4_dy  <= n4_dy;
            r4_f   <= r3_f;
            r5_mx  <= r4_dx[DQ_W-1] ? ng_dx[MAG_W-1:0] : r4_dx[MAG_W-1:0];
            r5_my  <= r4_dy[DQ_W-1] ? ng_dy[MAG_W-1:0] : r4_dy[MAG_W-1:0];
            r5_sx  <= r4_dx[DQ_W-1];
            r5_sy  <= r4_dy[DQ_W-1];
            r5_f   <= r4_f;
            r6_lox <= n6_lox;
            r6_loy <= n6_loy;
            r6_hix <= n6_hix;
            r6_hiy <= n6_hiy;
            r6_sx  <= r5_sx;
            r6_sy  <= r5_sy;
            r6_f   <= r5_f;
            r7_out <= n7_out;
        end
    end

endmodule

// ----- rtl/nd_point_projection.sv -----
// Throughput: one point per clock unless a full queue stalls the pipeline; set
// by the one-bit-per-stage pipelined divider (42 stages) and the registered
// multiply stages around it.
// Reset (synchronous, active low) empties both queues and all pipeline valids
// and loads every configuration register with its default value.
module nd_point_projection #(
    parameter int DIMENSION = ndp_pkg::DEF_DIM
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [ndp_pkg::COORD_W-1:0] i_coord_0,
    input  logic signed [ndp_pkg::COORD_W-1:0] i_coord_1,
    input  logic signed [ndp_pkg::COORD_W-1:0] i_coord_2,
    input  logic signed [ndp_pkg::COORD_W-1:0] i_coord_3,
    input  logic signed [ndp_pkg::COORD_W-1:0] i_coord_4,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ndp_pkg::OUT_W-1:0]  o_screen_x,
    output logic signed [ndp_pkg::OUT_W-1:0]  o_screen_y,
    output logic                              o_visible,
    input  logic                              i_cfg_we,
    input  logic [ndp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ndp_pkg::REG_W-1:0]         i_cfg_data
);
    import ndp_pkg::*;

    localparam int MID_W = $bits(t_mid);
    localparam int RES_W = $bits(t_out);

    t_cfg                              r_cfg;
    logic [MAX_DIM-1:0][COORD_W-1:0]   coord;
    logic                              mid_push;
    logic                              mid_pop;
    logic                              mid_full;
    logic                              mid_empty;
    t_mid                              mid_in;
    t_mid                              mid_out;
    logic                              out_push;
    logic                              out_full;
    t_out                              out_in;
    t_out                              out_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_x           <= 60'd800;
            r_cfg.axis_y           <= 60'd3276800;
            r_cfg.view_normal      <= 60'd13421772800;
            r_cfg.camera_shift     <= 60'd1151795329738211328;
            r_cfg.perspective_mode <= 1'b0;
            r_cfg.inv_norm_x       <= 24'd167772;
            r_cfg.inv_norm_y       <= 24'd167772;
            r_cfg.normal_sq        <= 25'd640000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AXIS_X:       r_cfg.axis_x           <= i_cfg_data;
                CFG_AXIS_Y:       r_cfg.axis_y           <= i_cfg_data;
                CFG_VIEW_NORMAL:  r_cfg.view_normal      <= i_cfg_data;
                CFG_CAMERA_SHIFT: r_cfg.camera_shift     <= i_cfg_data;
                CFG_PERSPECTIVE:  r_cfg.perspective_mode <= i_cfg_data[0];
                CFG_INV_NORM_X:   r_cfg.inv_norm_x       <= i_cfg_data[INV_W-1:0];
                CFG_INV_NORM_Y:   r_cfg.inv_norm_y       <= i_cfg_data[INV_W-1:0];
                CFG_NORMAL_SQ:    r_cfg.normal_sq        <= i_cfg_data[NSQ_W-1:0];
                default: ;
            endcase
        end
    end

    assign coord[0] = i_coord_0;
    assign coord[1] = i_coord_1;
    assign coord[2] = i_coord_2;
    assign coord[3] = i_coord_3;
    assign coord[4] = i_coord_4;

    ndp_front #(
        .DIMENSION (DIMENSION)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_coord    (coord),
        .i_cfg      (r_cfg),
        .i_mid_full (mid_full),
        .o_full     (full),
        .o_mid_push (mid_push),
        .o_mid_data (mid_in)
    );

    ndp_fifo #(
        .W     (MID_W),
        .DEPTH (4)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_data  (mid_out)
    );

    ndp_back #(
        .DIMENSION (DIMENSION)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_out),
        .i_out_full  (out_full),
        .o_mid_pop   (mid_pop),
        .o_out_push  (out_push),
        .o_out_data  (out_in)
    );

    ndp_fifo #(
        .W     (RES_W),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_full  (out_full),
        .o_empty (empty),
        .o_data  (out_head)
    );

    assign o_screen_x = out_head.screen_x;
    assign o_screen_y = out_head.screen_y;
    assign o_visible  = out_head.visible;

endmodule

// ----- sim/tb_nd_point_projection.sv -----
// Self-checking testbench for nd_point_projection: random and directed points
// through both projection modes, checked against a fixed-point predictor.
// Depends on rtl/ndp_pkg.sv and rtl/nd_point_projection.sv.
module tb_nd_point_projection;
    import ndp_pkg::*;

    typedef struct {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        logic             vis;
    } t_screen_pt;

    class proj_scoreboard;
        logic [REG_W-1:0] ax, ay, nrm, shf;
        logic             persp;
        logic [INV_W-1:0] ivx, ivy;
        logic [NSQ_W-1:0] nsq;
        t_screen_pt       expected_points[$];
        int               n_errors, n_points, n_checked, n_persp, n_plane, n_behind;

        function new();
            ax = 60'd800; ay = 60'd3276800; nrm = 60'd13421772800;
            shf = 60'd1151795329738211328; persp = 1'b0;
            ivx = 24'd167772; ivy = 24'd167772; nsq = 25'd640000;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [REG_W-1:0] v);
            case (idx)
                CFG_AXIS_X:       ax = v;
                CFG_AXIS_Y:       ay = v;
                CFG_VIEW_NORMAL:  nrm = v;
                CFG_CAMERA_SHIFT: shf = v;
                CFG_PERSPECTIVE:  persp = v[0];
                CFG_INV_NORM_X:   ivx = v[INV_W-1:0];
                CFG_INV_NORM_Y:   ivy = v[INV_W-1:0];
                CFG_NORMAL_SQ:    nsq = v[NSQ_W-1:0];
                default: ;
            endcase
        endfunction

        function longint lane_of(logic [REG_W-1:0] r, int i);
            logic signed [LANE_W-1:0] l;
            l = r[i*LANE_W +: LANE_W];
            return longint'(l);
        endfunction

        function longint axis_dot(logic [REG_W-1:0] r, longint v[5]);
            longint acc;
            acc = 0;
            for (int i = 0; i < 5; i++) acc += lane_of(r, i) * v[i];
            return acc;
        endfunction

        // Q.7 dot times Q0.24 reciprocal, down to Q.4, rounded then saturated
        function logic [OUT_W-1:0] scale_to_screen(longint dv, logic [INV_W-1:0] inv);
            logic [63:0] m, hi, lo, r, iv;
            m = (dv < 0) ? 64'(-dv) : 64'(dv);
            iv = 64'(inv);
            hi = m >> 32;
            lo = m & 64'hFFFF_FFFF;
            if (hi >= (64'd1 << 30)) r = '1;
            else r = ((hi * iv) << 5) + ((lo * iv + (64'd1 << 26)) >> 27);
            if (dv < 0) begin
                if (r > 64'd8388608) return 24'h800000;
                return 24'(-r);
            end
            if (r > 64'd8388607) return 24'h7FFFFF;
            return r[OUT_W-1:0];
        endfunction

        function longint round_shift16(longint v);
            logic [63:0] m;
            m = (v < 0) ? 64'(-v) : 64'(v);
            m = (m + 64'd32768) >> 16;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function t_screen_pt predict_point(logic signed [COORD_W-1:0] c[5]);
            longint     p[5], q[5];
            longint     dn;
            logic [63:0] coef, mag;
            t_screen_pt r;
            for (int i = 0; i < 5; i++) p[i] = longint'(c[i]) - 16 * lane_of(shf, i);
            r.vis = 1'b1;
            if (!persp) begin
                r.sx = scale_to_screen(axis_dot(ax, p), ivx);
                r.sy = scale_to_screen(axis_dot(ay, p), ivy);
                return r;
            end
            n_persp++;
            dn = axis_dot(nrm, p);
            if (dn == 0) begin
                n_plane++;
                r.sx = (axis_dot(ax, p) >= 0) ? 24'h7FFFFF : 24'h800000;
                r.sy = (axis_dot(ay, p) >= 0) ? 24'h7FFFFF : 24'h800000;
                return r;
            end
            mag = (dn < 0) ? 64'(-dn) : 64'(dn);
            coef = (64'(nsq) << 17) / mag;
            for (int i = 0; i < 5; i++)
                q[i] = round_shift16(longint'(coef) * p[i]) - 2 * lane_of(nrm, i);
            r.sx = scale_to_screen(axis_dot(ax, q), ivx);
            r.sy = scale_to_screen(axis_dot(ay, q), ivy);
            r.vis = (dn < 0) ? 1'b0 : 1'b1;
            if (dn < 0) n_behind++;
            return r;
        endfunction

        function void note_point(logic signed [COORD_W-1:0] c[5]);
            n_points++;
            expected_points.insert(expected_points.size(), predict_point(c));
        endfunction

        function void check_result(logic [OUT_W-1:0] sx, logic [OUT_W-1:0] sy,
                                   logic vis);
            t_screen_pt e;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h vis=%b", $time, sx, sy, vis);
                n_errors++;
                return;
            end
            e = expected_points.pop_front();
            n_checked++;
            if (sx !== e.sx) begin
                $display("%0t: screen_x expected %h actual %h", $time, e.sx, sx);
                n_errors++;
            end
            if (sy !== e.sy) begin
                $display("%0t: screen_y expected %h actual %h", $time, e.sy, sy);
                n_errors++;
            end
            if (vis !== e.vis) begin
                $display("%0t: visible expected %b actual %b", $time, e.vis, vis);
                n_errors++;
            end
        endfunction
    endclass

    logic                       i_clk, i_rst_n;
    logic                       push, full, empty, pop;
    logic signed [COORD_W-1:0]  coord[5];
    logic signed [OUT_W-1:0]    o_screen_x, o_screen_y;
    logic                       o_visible;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [REG_W-1:0]           i_cfg_data;
    bit                         calm;
    proj_scoreboard             sb;

    nd_point_projection i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_coord_0(coord[0]), .i_coord_1(coord[1]), .i_coord_2(coord[2]),
        .i_coord_3(coord[3]), .i_coord_4(coord[4]),
        .empty(empty), .pop(pop),
        .o_screen_x(o_screen_x), .o_screen_y(o_screen_y), .o_visible(o_visible),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Sample both transfers with the values held before this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_point(coord);
            if (pop && !empty) sb.check_result(o_screen_x, o_screen_y, o_visible);
        end
    end

    initial begin
        #2000000;
        $display("tb_nd_point_projection: FAIL");
        $finish;
    end

    task automatic send_point(logic signed [COORD_W-1:0] c[5]);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        for (int i = 0; i < 5; i++) coord[i] <= c[i];
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [REG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    // Drop push and hold until every expected result has come back
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [REG_W-1:0] lanes_of_kind(int kind);
        logic [REG_W-1:0] v;
        v = REG_W'({$urandom, $urandom});
        case (kind)
            1: v = {5{12'h7FF}};
            2: v = {5{12'h800}};
            3: begin
                v = '0;
                v[$urandom_range(0, 4)*LANE_W +: LANE_W] = 12'($urandom_range(1, 4095));
            end
            4: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic configure(int kind, bit mode);
        write_reg(CFG_AXIS_X, lanes_of_kind(kind));
        write_reg(CFG_AXIS_Y, lanes_of_kind(kind == 4 ? 0 : kind));
        write_reg(CFG_VIEW_NORMAL, lanes_of_kind(kind == 4 ? 3 : kind));
        write_reg(CFG_CAMERA_SHIFT, lanes_of_kind($urandom_range(0, 3)));
        write_reg(CFG_PERSPECTIVE, {(REG_W-1)'({$urandom, $urandom}), mode});
        write_reg(CFG_INV_NORM_X, kind == 1 ? {REG_W{1'b1}} :
                                  kind == 4 ? '0 : REG_W'({$urandom, $urandom}));
        write_reg(CFG_INV_NORM_Y, kind == 2 ? 60'hFFFFFF : REG_W'({$urandom, $urandom}));
        write_reg(CFG_NORMAL_SQ, kind == 1 ? 60'h1FFFFFF :
                                 kind == 2 ? 60'd1 : REG_W'({$urandom, $urandom}));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly plausible points near the camera, some raw noise, field extremes and in-plane points
    task automatic send_random_point();
        logic signed [COORD_W-1:0] c[5];
        int                        sel;
        sel = $urandom_range(0, 7);
        for (int i = 0; i < 5; i++) begin
            logic signed [COORD_W-1:0] base;
            base = 16'(sb.lane_of(sb.shf, i) * 16);
            case (sel)
                0, 1:    c[i] = 16'($urandom);
                2:       c[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                3:       c[i] = base;
                4:       c[i] = (sb.lane_of(sb.nrm, i) != 0) ? base : 16'($urandom);
                default: c[i] = base + 16'($signed($urandom_range(0, 4095)) - 2048);
            endcase
        end
        send_point(c);
    endtask

    initial begin
        logic signed [COORD_W-1:0] c[5];
        sb = new();
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        pop        <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_AXIS_X;
        i_cfg_data <= '0;
        for (int i = 0; i < 5; i++) coord[i] <= '0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults, parallel: zero point, field extremes and a small point
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 5; i++)
                case (k)
                    0: c[i] = '0;
                    1: c[i] = 16'sh7FFF;
                    2: c[i] = 16'sh8000;
                    3: c[i] = (i % 2) ? 16'sh7FFF : 16'sh8000;
                    4: c[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
                    default: c[i] = 16'sh0010;
                endcase
            send_point(c);
        end
        drain();
        // Defaults, perspective: normal along lane 2 and shift of -5 there
        write_reg(CFG_PERSPECTIVE, 60'd1);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 5; i++) c[i] = 16'(k * 37 - 100);
            case (k)
                0: c[2] = -16'sd80;
                1: c[2] = 16'sh8000;
                2: c[2] = 16'sh7FFF;
                3: c[2] = -16'sd81;
                4: c[2] = -16'sd79;
                5: begin c[0] = 16'sh8000; c[1] = 16'sh8000; c[2] = -16'sd80; end
                6: begin for (int i = 0; i < 5; i++) c[i] = 16'sh7FFF; end
                default: begin for (int i = 0; i < 5; i++) c[i] = 16'sh8000; end
            endcase
            send_point(c);
        end
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            configure(ph % 5, ph % 2);
            calm = (ph == 8);
            for (int n = 0; n < 70; n++) send_random_point();
            drain();
        end

        repeat (60) @(posedge i_clk);
        $display("points sent %0d, results checked %0d", sb.n_points, sb.n_checked);
        $display("perspective points %0d, in-plane %0d, behind viewer %0d",
                 sb.n_persp, sb.n_plane, sb.n_behind);
        if (sb.n_errors == 0 && sb.expected_points.size() == 0)
            $display("tb_nd_point_projection: PASS");
        else
            $display("tb_nd_point_projection: FAIL");
        $finish;
    end

    // Result side: random stall bursts, none once the run turns calm
    initial begin
        @(posedge i_rst_n);
        forever begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 1) == 1) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end
endmodule
